### rtl/core/rbdm_pkg.sv
// Shared types and codes for the displacing ring slot buffer.
package rbdm_pkg;

   localparam int KEY_W  = 31;
   localparam int KIND_W = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DISPLACE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DRAIN   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DISP,
      ST_SWEEP,
      ST_OUT
   } state_type;

endpackage

### rtl/core/ring_buffer_displace_min_drain_top.sv
// Displacing ring slot buffer with ascending drain; keys in one synchronous memory.
// Insert: free-slot scan from the ring pointer, one full bit a cycle, then the result.
// A full buffer adds a memory read to fetch the displaced key.
// Drain: stored keys leave in ascending order; each minimum needs one sweep of the key memory port.
// One transaction is processed at a time; the result register frees the input side.
// Reset (synchronous, active high) clears full bits, fill count, ring pointer and control.
module ring_buffer_displace_min_drain_top
   import rbdm_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_opcode,
   input  logic [KEY_W-1:0]  req_package_key,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [KEY_W-1:0]  rsp_item_key,
   output logic              rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(p + IDX_W'(1));
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] p);
      return (p == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(p - IDX_W'(1));
   endfunction

   state_type state_ff, state_in;

   logic              op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [IDX_W-1:0]  ptr_ff;
   logic [IDX_W-1:0]  scan_idx_ff;
   logic [IDX_W-1:0]  scan_cnt_ff;
   logic [DEPTH-1:0]  full_ff;
   logic [CNT_W-1:0]  cnt_ff;

   logic [KEY_W-1:0]  keys_mem [DEPTH];
   logic [KEY_W-1:0]  rd_data_ff;

   logic [CNT_W-1:0]  rd_cnt_ff;
   logic              cmp_vld_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              best_vld_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [KEY_W-1:0]  best_key_ff;

   logic [KIND_W-1:0] pend_kind_ff;
   logic [KEY_W-1:0]  pend_key_ff;

   logic              rsp_valid_ff;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [KEY_W-1:0]  rsp_item_key_ff;
   logic              rsp_last_ff;

   logic              out_free;
   logic              slot_free;
   logic              scan_wrap;
   logic [IDX_W-1:0]  disp_idx;
   logic              sweep_last;
   logic              cand_take;
   logic [IDX_W-1:0]  best_idx_nx;
   logic [KEY_W-1:0]  best_key_nx;
   logic              more_drain;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic              emit;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign slot_free   = !full_ff[scan_idx_ff];
   assign scan_wrap   = (scan_cnt_ff == IDX_W'(DEPTH - 1));
   assign disp_idx    = ring_prev(ptr_ff);
   assign sweep_last  = cmp_vld_ff && (cmp_idx_ff == IDX_W'(DEPTH - 1));
   assign cand_take   = cmp_vld_ff && full_ff[cmp_idx_ff]
                        && (!best_vld_ff || (rd_data_ff < best_key_ff));
   assign best_idx_nx = cand_take ? cmp_idx_ff : best_idx_ff;
   assign best_key_nx = cand_take ? rd_data_ff : best_key_ff;
   assign more_drain  = (pend_kind_ff == KIND_DRAIN) && (cnt_ff > CNT_W'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_DRAIN) begin
                  state_in = (cnt_ff == '0) ? ST_OUT : ST_SWEEP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (slot_free) begin
               state_in = ST_OUT;
            end else if (scan_wrap) begin
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            state_in = ST_OUT;
         end
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = more_drain ? ST_SWEEP : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      rd_addr   = rd_cnt_ff[IDX_W-1:0];
      wr_en     = 1'b0;
      wr_addr   = scan_idx_ff;
      emit      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_SCAN: begin
            if (slot_free) begin
               wr_en = 1'b1;
            end else if (scan_wrap) begin
               rd_en   = 1'b1;
               rd_addr = disp_idx;
            end
         end
         ST_DISP: begin
            wr_en   = 1'b1;
            wr_addr = disp_idx;
         end
         ST_SWEEP: begin
            rd_en = (rd_cnt_ff != CNT_W'(DEPTH));
         end
         ST_OUT: begin
            emit = out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         keys_mem[wr_addr] <= key_ff;
      end
      if (rd_en) begin
         rd_data_ff <= keys_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         full_ff      <= '0;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         best_vld_ff  <= 1'b0;
         rd_cnt_ff    <= '0;
      end else begin
         state_ff <= state_in;

         if (emit) begin
            rsp_valid_ff    <= 1'b1;
            rsp_kind_ff     <= pend_kind_ff;
            rsp_item_key_ff <= pend_key_ff;
            rsp_last_ff     <= !more_drain;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff        <= req_opcode;
                  key_ff       <= req_package_key;
                  scan_idx_ff  <= ptr_ff;
                  scan_cnt_ff  <= '0;
                  pend_kind_ff <= KIND_EMPTY;
                  pend_key_ff  <= '0;
                  rd_cnt_ff    <= '0;
                  cmp_vld_ff   <= 1'b0;
                  best_vld_ff  <= 1'b0;
               end
            end
            ST_SCAN: begin
               if (slot_free) begin
                  full_ff[scan_idx_ff] <= 1'b1;
                  cnt_ff               <= CNT_W'(cnt_ff + CNT_W'(1));
                  ptr_ff               <= ring_next(scan_idx_ff);
                  pend_kind_ff         <= KIND_ACCEPT;
                  pend_key_ff          <= '0;
               end else begin
                  scan_idx_ff <= ring_next(scan_idx_ff);
                  scan_cnt_ff <= IDX_W'(scan_cnt_ff + IDX_W'(1));
               end
            end
            ST_DISP: begin
               pend_kind_ff <= KIND_DISPLACE;
               pend_key_ff  <= rd_data_ff;
            end
            ST_SWEEP: begin
               if (rd_en) begin
                  rd_cnt_ff <= CNT_W'(rd_cnt_ff + CNT_W'(1));
               end
               cmp_vld_ff  <= rd_en;
               cmp_idx_ff  <= rd_cnt_ff[IDX_W-1:0];
               best_idx_ff <= best_idx_nx;
               best_key_ff <= best_key_nx;
               if (cand_take) begin
                  best_vld_ff <= 1'b1;
               end
               if (sweep_last) begin
                  pend_kind_ff <= KIND_DRAIN;
                  pend_key_ff  <= best_key_nx;
               end
            end
            ST_OUT: begin
               if (out_free && (pend_kind_ff == KIND_DRAIN)) begin
                  full_ff[best_idx_ff] <= 1'b0;
                  cnt_ff               <= CNT_W'(cnt_ff - CNT_W'(1));
                  rd_cnt_ff            <= '0;
                  cmp_vld_ff           <= 1'b0;
                  best_vld_ff          <= 1'b0;
               end
            end
            default: begin
               cmp_vld_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_item_key = rsp_item_key_ff;
   assign rsp_last     = rsp_last_ff;

   a_count_matches_full: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) == $countones(full_ff))
      else $error("fill count differs from number of full slots");

   a_displace_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DISP) |-> (&full_ff))
      else $error("displacement with a free slot present");

   a_drain_last_empties: assert property (@(posedge clock) disable iff (reset)
      (emit && (pend_kind_ff == KIND_DRAIN) && !more_drain) |=> (cnt_ff == '0))
      else $error("buffer not empty after final drained key");

   a_drain_op_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (op_ff == OP_DRAIN))
      else $error("sweep entered for an insert");

endmodule

### dv/ring_buffer_displace_min_drain_checker.sv
// Result checker for the displacing ring slot buffer: tracks slot state and compares results.
module ring_buffer_displace_min_drain_checker
   import rbdm_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_opcode,
   input  logic [KEY_W-1:0]  req_package_key,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [KIND_W-1:0] rsp_kind,
   input  logic [KEY_W-1:0]  rsp_item_key,
   input  logic              rsp_last,
   output int                mismatch_count,
   output int                awaited_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;
      logic              last_flag;
   } slot_result_type;

   logic [KEY_W-1:0] slot_key [DEPTH];
   logic             slot_used [DEPTH];
   int unsigned      ring_ptr;
   slot_result_type  awaited_results [$];
   int               mismatches;

   initial mismatches = 0;

   function automatic int unsigned ring_after(int unsigned p);
      return (p == DEPTH - 1) ? 0 : p + 1;
   endfunction

   function automatic void await_result(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                        logic last_flag);
      slot_result_type r;
      r.kind = kind;
      r.key = key;
      r.last_flag = last_flag;
      awaited_results = {awaited_results, r};
   endfunction

   function automatic void insert_key(logic [KEY_W-1:0] key);
      int unsigned p;
      int unsigned scanned;
      p = ring_ptr;
      scanned = 0;
      while (slot_used[p] && scanned < DEPTH) begin
         p = ring_after(p);
         scanned++;
      end
      if (slot_used[p]) begin
         // displace the slot behind the pointer; pointer stays
         p = (ring_ptr == 0) ? DEPTH - 1 : ring_ptr - 1;
         await_result(KIND_DISPLACE, slot_key[p], 1'b1);
         slot_key[p] = key;
      end else begin
         slot_key[p] = key;
         slot_used[p] = 1'b1;
         ring_ptr = ring_after(p);
         await_result(KIND_ACCEPT, '0, 1'b1);
      end
   endfunction

   function automatic void drain_ascending();
      int unsigned total;
      int unsigned best;
      int unsigned n;
      int unsigned i;
      total = 0;
      for (i = 0; i < DEPTH; i++)
         if (slot_used[i]) total++;
      if (total == 0) begin
         await_result(KIND_EMPTY, '0, 1'b1);
      end else begin
         for (n = 0; n < total; n++) begin
            best = DEPTH;
            for (i = 0; i < DEPTH; i++)
               if (slot_used[i] && (best == DEPTH || slot_key[i] < slot_key[best])) best = i;
            await_result(KIND_DRAIN, slot_key[best], (n + 1 == total));
            slot_used[best] = 1'b0;
         end
      end
   endfunction

   always @(posedge clock) begin : watch
      slot_result_type got;
      slot_result_type want;
      int i;
      if (reset) begin
         for (i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
         ring_ptr = 0;
         awaited_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (req_opcode == OP_INSERT) insert_key(req_package_key);
            else drain_ascending();
         end
         if (rsp_valid && !rsp_stall) begin
            got.kind = rsp_kind;
            got.key = rsp_item_key;
            got.last_flag = rsp_last;
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected result kind %0d key %0d last %0d", $realtime,
                           got.kind, got.key, got.last_flag);
            end else begin
               want = awaited_results.pop_front();
               if (got.kind !== want.kind || got.key !== want.key ||
                   got.last_flag !== want.last_flag) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: expected %0d/%0d/%0d (kind/key/last), got %0d/%0d/%0d",
                              $realtime, want.kind, want.key, want.last_flag,
                              got.kind, got.key, got.last_flag);
               end
            end
         end
      end
      mismatch_count <= mismatches;
      awaited_count <= awaited_results.size();
   end

endmodule

### dv/ring_buffer_displace_min_drain_top_test.sv
// Testbench top for the displacing ring slot buffer: stimulus, flow control and verdict.
module ring_buffer_displace_min_drain_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rbdm_pkg::*;

   localparam int DEPTH = 8;
   localparam int RANDOM_ITEMS = 345;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER = 60;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [KEY_W-1:0] KEY_MAX = 31'd2147483646;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_opcode;
   logic [KEY_W-1:0]  req_package_key;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [KIND_W-1:0] rsp_kind;
   logic [KEY_W-1:0]  rsp_item_key;
   logic              rsp_last;
   int                fail_count;
   int                awaited_count;
   int                sent_count;

   ring_buffer_displace_min_drain_top #(.DEPTH(DEPTH)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_package_key (req_package_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_item_key    (rsp_item_key),
      .rsp_last        (rsp_last)
   );

   ring_buffer_displace_min_drain_checker #(.DEPTH(DEPTH)) result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_package_key (req_package_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_item_key    (rsp_item_key),
      .rsp_last        (rsp_last),
      .mismatch_count  (fail_count),
      .awaited_count   (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   task automatic send(input logic opcode, input logic [KEY_W-1:0] key);
      req_valid <= 1'b1;
      req_opcode <= opcode;
      req_package_key <= key;
      do @(posedge clock); while (req_stall);
      sent_count <= sent_count + 1;
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_count != 0);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] k;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: k = KEY_W'($urandom_range(0, KEY_MAX));
         5, 6: k = KEY_W'($urandom_range(0, 15));
         7: begin
            case ($urandom_range(0, 3))
               0: k = '0;
               1: k = KEY_MAX;
               2: k = 31'd1;
               default: k = KEY_MAX - 1;
            endcase
         end
         default: begin
            k = KEY_W'($urandom);
            if (k > KEY_MAX) k = KEY_MAX;
         end
      endcase
      return k;
   endfunction

   initial begin : receiver
      int mode_left;
      int stall_pct;
      bit held;
      rsp_stall <= 1'b0;
      held = 1'b0;
      mode_left = 0;
      stall_pct = 0;
      forever begin
         @(posedge clock);
         if (!held && sent_count >= HOLD_AFTER) begin
            // hold off so the buffer backs up into the request side
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(10, 60);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 20;
               2: stall_pct = 50;
               default: stall_pct = 80;
            endcase
         end
         mode_left--;
         rsp_stall <= ($urandom_range(1, 100) <= stall_pct);
      end
   end

   initial begin : stimulus
      int i;
      int burst_left;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= OP_INSERT;
      req_package_key <= '0;
      sent_count <= 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send(OP_DRAIN, KEY_MAX);
      send(OP_INSERT, '0);
      send(OP_INSERT, KEY_MAX);
      send(OP_INSERT, 31'd1);
      send(OP_INSERT, 31'h2AAA_AAAA);
      send(OP_INSERT, 31'h5555_5555);
      send(OP_INSERT, 31'd5);
      send(OP_INSERT, 31'd5);
      send(OP_INSERT, 31'd1);
      send(OP_INSERT, 31'd3);
      send(OP_INSERT, KEY_MAX);
      send(OP_DRAIN, 31'h5555_5555);
      send(OP_DRAIN, '0);
      send(OP_INSERT, 31'd9);
      send(OP_DRAIN, 31'h2AAA_AAAA);
      wait_all_results();

      burst_left = 0;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) wait_all_results();
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            idle_gap($urandom_range(0, 6));
         end
         burst_left--;
         send(($urandom_range(0, 8) == 0) ? OP_DRAIN : OP_INSERT, pick_key());
      end

      wait_all_results();
      repeat (4 * (DEPTH + 2)) @(posedge clock);
      if (fail_count == 0 && awaited_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
